// ===== design/resizing_stack_tracker_core_macros.svh =====
// Assertion macros used by the checker file.
// Each expects signals named clock and reset in the enclosing scope.
`ifndef RESIZING_STACK_TRACKER_CORE_MACROS_SVH
`define RESIZING_STACK_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, quiet while reset is high
`define RST_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stack tracker check failed");

// Next-cycle implication, quiet while reset is high
`define RST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stack tracker check failed");

`endif

// ===== design/rst_pkg.sv =====
`default_nettype none

package rst_pkg;

   // Physical store
   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   // Field widths fixed by the interface
   localparam int WORD_W  = 32;
   localparam int FIELD_W = 11;
   localparam int CMP_W   = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;

   localparam logic [FIELD_W-1:0] CAP_MAX   = 11'd2047;
   localparam logic [FIELD_W-1:0] CAP_RESET = 11'd10;

   typedef enum logic {
      ACT_PUSH = 1'b0,
      ACT_POP  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      RSZ_NONE   = 2'd0,
      RSZ_GROW   = 2'd1,
      RSZ_SHRINK = 2'd2
   } resize_type;

   // One access to the stack memory
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [WORD_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== design/rst_mem.sv =====
`default_nettype none

module rst_mem
   import rst_pkg::*;
(
   input  wire logic              clock,
   input  wire mem_req_type       mem_req,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem_array [STORE_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_array[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= mem_array[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/rst_ctrl.sv =====
`default_nettype none

module rst_ctrl
   import rst_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               action,
   input  wire logic  [WORD_W-1:0] value,
   input  wire logic               csr_we,
   input  wire logic [FIELD_W-1:0] csr_wdata,
   input  wire logic  [WORD_W-1:0] rd_data,
   output mem_req_type             mem_req,
   output logic                    rsp_valid,
   output logic       [WORD_W-1:0] rsp_popped_value,
   output logic                    rsp_empty_error,
   output logic                    rsp_overflow,
   output logic              [1:0] rsp_resized,
   output logic      [FIELD_W-1:0] rsp_capacity_now,
   output logic      [FIELD_W-1:0] rsp_largest_capacity,
   output logic      [FIELD_W-1:0] rsp_item_count
);

   // Tracker state
   logic   [CNT_W-1:0] count_ff, count_in;
   logic [FIELD_W-1:0] cap_ff, cap_in;
   logic [FIELD_W-1:0] peak_ff, peak_in;
   logic               grown_ff, grown_in;

   // Result flags of the transaction in flight
   logic               valid_ff, valid_in;
   logic               pop_ok_ff, pop_ok_in;
   logic               empty_ff, empty_in;
   logic               ovf_ff, ovf_in;
   resize_type         resized_ff, resized_in;

   logic   [CNT_W-1:0] count_dec;
   logic [FIELD_W:0]   cap_dbl;
   logic [FIELD_W-1:0] cap_grow;
   logic [FIELD_W-1:0] cap_restart;
   logic   [CMP_W-1:0] count_wide;
   logic   [CMP_W-1:0] count_dec_wide;
   logic   [CMP_W-1:0] cap_wide;
   logic   [CMP_W-1:0] half_wide;

   assign count_dec      = count_ff - CNT_W'(1);
   assign cap_dbl        = {cap_ff, 1'b0};
   assign cap_grow       = (cap_dbl > {1'b0, CAP_MAX}) ? CAP_MAX : cap_dbl[FIELD_W-1:0];
   assign cap_restart    = (csr_wdata == '0) ? FIELD_W'(1) : csr_wdata;
   assign count_wide     = CMP_W'(count_ff);
   assign count_dec_wide = CMP_W'(count_dec);
   assign cap_wide       = CMP_W'(cap_ff);
   assign half_wide      = CMP_W'(cap_ff >> 1);

   // Work out the next state, the memory access and the result flags
   always_comb begin
      count_in   = count_ff;
      cap_in     = cap_ff;
      peak_in    = peak_ff;
      grown_in   = grown_ff;
      valid_in   = accept;
      pop_ok_in  = 1'b0;
      empty_in   = 1'b0;
      ovf_in     = 1'b0;
      resized_in = RSZ_NONE;
      mem_req    = '{we: 1'b0, waddr: count_ff[ADDR_W-1:0], wdata: value,
                     re: 1'b0, raddr: count_dec[ADDR_W-1:0]};

      if (accept) begin
         unique case (action)
            ACT_PUSH: begin
               if (count_ff == CNT_W'(STORE_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  if ((count_wide >= cap_wide) && (cap_ff < CAP_MAX)) begin
                     cap_in     = cap_grow;
                     peak_in    = (cap_grow > peak_ff) ? cap_grow : peak_ff;
                     grown_in   = 1'b1;
                     resized_in = RSZ_GROW;
                  end
                  mem_req.we = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
               end
            end
            ACT_POP: begin
               if (count_ff == '0) begin
                  empty_in = 1'b1;
               end else begin
                  mem_req.re = 1'b1;
                  pop_ok_in  = 1'b1;
                  count_in   = count_dec;
                  if (grown_ff && (count_dec_wide < half_wide)) begin
                     cap_in     = cap_ff >> 1;
                     resized_in = RSZ_SHRINK;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Hold the tracker state; a register write restarts it
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         peak_ff      <= '0;
         grown_ff     <= 1'b0;
      end else if (csr_we) begin
         count_ff     <= '0;
         cap_ff       <= cap_restart;
         peak_ff      <= '0;
         grown_ff     <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         peak_ff      <= peak_in;
         grown_ff     <= grown_in;
      end
   end

   // Advance the result strobe and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pop_ok_ff  <= 1'b0;
         empty_ff   <= 1'b0;
         ovf_ff     <= 1'b0;
         resized_ff <= RSZ_NONE;
      end else begin
         valid_ff   <= valid_in;
         pop_ok_ff  <= pop_ok_in;
         empty_ff   <= empty_in;
         ovf_ff     <= ovf_in;
         resized_ff <= resized_in;
      end
   end

   // Present the result; the state registers already hold post-transaction values
   assign rsp_valid            = valid_ff;
   assign rsp_popped_value     = pop_ok_ff ? rd_data : (empty_ff ? '1 : '0);
   assign rsp_empty_error      = empty_ff;
   assign rsp_overflow         = ovf_ff;
   assign rsp_resized          = resized_ff;
   assign rsp_capacity_now     = cap_ff;
   assign rsp_largest_capacity = peak_ff;
   assign rsp_item_count       = count_wide[FIELD_W-1:0];

endmodule

`default_nettype wire

// ===== design/resizing_stack_tracker_core.sv =====
`default_nettype none
// Channel     Handshake             Payload
// request     start / busy          req_action, req_value
// response    rsp_valid (strobe)    rsp_popped_value .. rsp_item_count
// register    csr_we                csr_wdata (start capacity)
//
// One transaction per cycle; busy stays low. The result appears in the cycle
// after acceptance; the popped value comes from the registered read port of the stack memory.
// Reset is synchronous and active high; the stack memory is not cleared,
// as only entries below the item count are ever read.
// The receiver cannot stall: each result is shown for exactly one cycle.
// A write to csr_wdata restarts the tracker with the new start capacity.

module resizing_stack_tracker_core
   import rst_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_action,
   input  wire logic   [WORD_W-1:0] req_value,
   input  wire logic                csr_we,
   input  wire logic  [FIELD_W-1:0] csr_wdata,
   output logic                     rsp_valid,
   output logic        [WORD_W-1:0] rsp_popped_value,
   output logic                     rsp_empty_error,
   output logic                     rsp_overflow,
   output logic               [1:0] rsp_resized,
   output logic       [FIELD_W-1:0] rsp_capacity_now,
   output logic       [FIELD_W-1:0] rsp_largest_capacity,
   output logic       [FIELD_W-1:0] rsp_item_count
);

   mem_req_type       mem_req;
   logic [WORD_W-1:0] rd_data;
   logic              accept;

   // Take a transaction whenever one is offered
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   rst_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .accept               (accept),
      .action               (req_action),
      .value                (req_value),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .rd_data              (rd_data),
      .mem_req              (mem_req),
      .rsp_valid            (rsp_valid),
      .rsp_popped_value     (rsp_popped_value),
      .rsp_empty_error      (rsp_empty_error),
      .rsp_overflow         (rsp_overflow),
      .rsp_resized          (rsp_resized),
      .rsp_capacity_now     (rsp_capacity_now),
      .rsp_largest_capacity (rsp_largest_capacity),
      .rsp_item_count       (rsp_item_count)
   );

   rst_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire

// ===== design/rst_checker.sv =====
`default_nettype none
`include "resizing_stack_tracker_core_macros.svh"

module rst_checker
   import rst_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_valid,
   input wire logic   [WORD_W-1:0] rsp_popped_value,
   input wire logic                rsp_empty_error,
   input wire logic                rsp_overflow,
   input wire logic          [1:0] rsp_resized,
   input wire logic  [FIELD_W-1:0] rsp_capacity_now,
   input wire logic  [FIELD_W-1:0] rsp_largest_capacity,
   input wire logic  [FIELD_W-1:0] rsp_item_count
);

   logic accept_now;
   logic empty_result_ok;
   logic grow_result;
   logic peak_ok;
   logic count_to_zero;
   logic count_step_ok;

   assign accept_now      = start && !busy;
   assign empty_result_ok = (rsp_item_count == '0) && (rsp_popped_value == '1)
                            && (rsp_resized == RSZ_NONE) && !rsp_overflow;
   assign grow_result     = rsp_valid && (rsp_resized == RSZ_GROW);
   assign peak_ok         = rsp_largest_capacity >= rsp_capacity_now;
   assign count_to_zero   = rsp_valid && !rsp_overflow && !rsp_empty_error
                            && (rsp_item_count == FIELD_W'(0));
   assign count_step_ok   = rsp_overflow || (rsp_item_count <= FIELD_W'(1));

   // Every accepted transaction gives its result in the next cycle
   `RST_ASSERT_NEXT(a_result_follows, accept_now, rsp_valid)

   // An empty pop leaves nothing on the stack, reports -1 and no resize
   `RST_ASSERT_NOW(a_empty_pop, rsp_valid && rsp_empty_error, empty_result_ok)

   // A doubling never leaves the capacity above the recorded peak
   `RST_ASSERT_NOW(a_peak_covers, grow_result, peak_ok)

   // When a result leaves the stack empty and a new transaction is accepted, the next result shows at most one item
   `RST_ASSERT_NEXT(a_count_step, count_to_zero && accept_now, count_step_ok)

endmodule

bind resizing_stack_tracker_core rst_checker u_rst_checker (.*);

`default_nettype wire
